// File: sv/looping_ad_envelope_assert.svh
// Assertion macros for the envelope RTL.
// Each macro expands to one labeled concurrent assertion with an asynchronous reset guard.
`ifndef LOOPING_AD_ENVELOPE_ASSERT_SVH
`define LOOPING_AD_ENVELOPE_ASSERT_SVH

// Implication checked in the same cycle.
`define LAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LAE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lae_pkg.sv
// Package for the looping attack/decay envelope: widths, register map and shared types.
// No dependencies; the RTL files refer to it by scoped names.
package lae_pkg;

    localparam int TIME_BITS  = 16;
    localparam int CFG_TIME_W = 16;
    localparam int LEVEL_W    = 8;
    localparam int PROD_W     = CFG_TIME_W + LEVEL_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int WIDE_W     = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
    localparam int SUM_W      = WIDE_W + 1;
    localparam int ADDR_W     = 4;
    localparam int IDX_W      = ADDR_W - 2;
    localparam int DATA_W     = 32;
    localparam int IN_USER_W  = 4;
    localparam int OUT_USER_W = 3;

    localparam logic [LEVEL_W-1:0]   LEVEL_PEAK = {LEVEL_W{1'b1}};
    localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};

    localparam logic [IDX_W-1:0] REG_ATTACK_TIME = 2'd0;
    localparam logic [IDX_W-1:0] REG_DECAY_TIME  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LOOP_ENABLE = 2'd2;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] attack_time;
        logic [CFG_TIME_W-1:0] decay_time;
        logic                  loop_enable;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [PROD_W-1:0]     dividend;
        logic [CFG_TIME_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: sv/looping_ad_envelope.sv
// Top level of the looping attack/decay envelope: configuration registers and the core.
// Depends on lae_pkg and lae_core.

// Each input beat advances the phase timer by ms_elapsed, applies the flag clears, trigger
// and release, and yields one output beat with the new level and flags. A new beat is not
// accepted until the current one has finished, most of which is spent in the 24-step serial
// divider that forms elapsed times span over duration; a phase whose duration is zero skips
// the divider. A result waits in the output register while the next beat is accepted, and
// the block stalls before posting a new result for as long as the previous one is still
// waiting there. Registers at byte addresses 0, 4 and 8 hold attack_time, decay_time and
// loop_enable and should be written only while no beat is in progress.
module looping_ad_envelope
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lae_pkg::ADDR_W-1:0]          paddr,
    input  logic [lae_pkg::DATA_W-1:0]          pwdata,
    output logic [lae_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: ms_elapsed[15:0]
    input  logic [lae_pkg::CFG_TIME_W-1:0]      s_tdata,
    // s_tuser: trigger, release_req, clear_rise_flag, clear_cycle_flag
    input  logic [lae_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: level[7:0]
    output logic [lae_pkg::LEVEL_W-1:0]         m_tdata,
    // m_tuser: end_of_rise, end_of_cycle, in_attack
    output logic [lae_pkg::OUT_USER_W-1:0]      m_tuser
);

    lae_pkg::cfg_t              cfg_reg, cfg_next;
    logic [lae_pkg::IDX_W-1:0]  reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[lae_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                lae_pkg::REG_ATTACK_TIME: cfg_next.attack_time = pwdata[lae_pkg::CFG_TIME_W-1:0];
                lae_pkg::REG_DECAY_TIME:  cfg_next.decay_time  = pwdata[lae_pkg::CFG_TIME_W-1:0];
                lae_pkg::REG_LOOP_ENABLE: cfg_next.loop_enable = pwdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lae_pkg::REG_ATTACK_TIME: prdata = lae_pkg::DATA_W'(cfg_reg.attack_time);
            lae_pkg::REG_DECAY_TIME:  prdata = lae_pkg::DATA_W'(cfg_reg.decay_time);
            lae_pkg::REG_LOOP_ENABLE: prdata = lae_pkg::DATA_W'(cfg_reg.loop_enable);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lae_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: sv/lae_divider.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on lae_pkg for widths and the request and response structs.
module lae_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  lae_pkg::div_req_t  req,
    output lae_pkg::div_rsp_t  rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [lae_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lae_pkg::CFG_TIME_W-1:0]      rem_reg, rem_next;
    logic [lae_pkg::PROD_W-1:0]          quo_reg, quo_next;
    logic [lae_pkg::CFG_TIME_W:0]        trial;
    logic [lae_pkg::CFG_TIME_W:0]        shifted;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[lae_pkg::PROD_W-1]};
        trial     = shifted - {1'b0, req.divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = lae_pkg::DIV_CNT_W'(lae_pkg::DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[lae_pkg::CFG_TIME_W])
            begin
                rem_next = trial[lae_pkg::CFG_TIME_W-1:0];
                quo_next = {quo_reg[lae_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[lae_pkg::CFG_TIME_W-1:0];
                quo_next = {quo_reg[lae_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - lae_pkg::DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[lae_pkg::LEVEL_W-1:0];

endmodule

// File: sv/lae_core.sv
// Envelope sequencer: phase state, timer, flags and the output register.
// Depends on lae_pkg, lae_divider and the assertion macro header.
`include "looping_ad_envelope_assert.svh"

module lae_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lae_pkg::cfg_t                       cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lae_pkg::CFG_TIME_W-1:0]      s_tdata,
    input  logic [lae_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lae_pkg::LEVEL_W-1:0]         m_tdata,
    output logic [lae_pkg::OUT_USER_W-1:0]      m_tuser
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                                state_reg, state_next;
    logic [lae_pkg::TIME_BITS-1:0]         phase_reg, phase_next;
    logic                                  attack_reg, attack_next;
    logic [lae_pkg::LEVEL_W-1:0]           start_reg, start_next;
    logic [lae_pkg::LEVEL_W-1:0]           level_reg, level_next;
    logic                                  rise_reg, rise_next;
    logic                                  cycle_reg, cycle_next;
    logic [lae_pkg::CFG_TIME_W-1:0]        t_reg, t_next;
    logic                                  tge_reg, tge_next;
    logic                                  zero_reg, zero_next;
    logic                                  mvalid_reg, mvalid_next;
    logic [lae_pkg::LEVEL_W-1:0]           mdata_reg, mdata_next;
    logic [lae_pkg::OUT_USER_W-1:0]        muser_reg, muser_next;

    logic [lae_pkg::CFG_TIME_W-1:0]        time_sel;
    logic [lae_pkg::LEVEL_W-1:0]           span;
    logic [lae_pkg::SUM_W-1:0]             sum;
    logic [lae_pkg::WIDE_W-1:0]            phase_wide;
    logic [lae_pkg::WIDE_W-1:0]            time_wide;
    logic                                  out_free;
    lae_pkg::div_req_t                     div_req;
    lae_pkg::div_rsp_t                     div_rsp;

    lae_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign time_sel   = attack_reg ? cfg.attack_time : cfg.decay_time;
    assign span       = attack_reg ? lae_pkg::LEVEL_W'(lae_pkg::LEVEL_PEAK - start_reg)
                                   : start_reg;
    assign sum        = lae_pkg::SUM_W'(phase_reg) + lae_pkg::SUM_W'(s_tdata);
    assign phase_wide = lae_pkg::WIDE_W'(phase_reg);
    assign time_wide  = lae_pkg::WIDE_W'(time_sel);
    assign out_free   = !mvalid_reg || m_tready;

    always_comb
    begin
        logic                        att_v;
        logic [lae_pkg::LEVEL_W-1:0] lvl_v;
        state_next       = state_reg;
        phase_next       = phase_reg;
        attack_next      = attack_reg;
        start_next       = start_reg;
        level_next       = level_reg;
        rise_next        = rise_reg;
        cycle_next       = cycle_reg;
        t_next           = t_reg;
        tge_next         = tge_reg;
        zero_next        = zero_reg;
        mvalid_next      = mvalid_reg && !m_tready;
        mdata_next       = mdata_reg;
        muser_next       = muser_reg;
        div_req.start    = 1'b0;
        div_req.dividend = lae_pkg::PROD_W'(t_reg) * lae_pkg::PROD_W'(span);
        div_req.divisor  = time_sel;
        att_v            = attack_reg;
        lvl_v            = level_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[2])
                    begin
                        rise_next = 1'b0;
                    end
                    if (s_tuser[3])
                    begin
                        cycle_next = 1'b0;
                    end
                    if (sum > lae_pkg::SUM_W'(lae_pkg::TIME_MAX))
                    begin
                        phase_next = lae_pkg::TIME_MAX;
                    end
                    else
                    begin
                        phase_next = sum[lae_pkg::TIME_BITS-1:0];
                    end
                    if (s_tuser[0])
                    begin
                        att_v      = 1'b1;
                        phase_next = '0;
                        start_next = level_reg;
                    end
                    if (s_tuser[1] && att_v)
                    begin
                        att_v      = 1'b0;
                        phase_next = '0;
                        start_next = level_reg;
                    end
                    attack_next = att_v;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (phase_wide < time_wide)
                begin
                    t_next   = phase_wide[lae_pkg::CFG_TIME_W-1:0];
                    tge_next = 1'b0;
                end
                else
                begin
                    t_next   = time_sel;
                    tge_next = 1'b1;
                end
                zero_next  = (time_sel == '0);
                state_next = (time_sel == '0) ? S_DONE : S_MUL;
            end
            S_MUL:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (zero_reg)
                    begin
                        lvl_v = attack_reg ? lae_pkg::LEVEL_PEAK : '0;
                    end
                    else if (attack_reg)
                    begin
                        lvl_v = start_reg + div_rsp.quotient;
                    end
                    else
                    begin
                        lvl_v = start_reg - div_rsp.quotient;
                    end
                    level_next = lvl_v;
                    att_v      = attack_reg;
                    if (tge_reg && attack_reg)
                    begin
                        att_v      = 1'b0;
                        phase_next = '0;
                        start_next = lvl_v;
                        rise_next  = 1'b1;
                    end
                    else if (tge_reg && cfg.loop_enable)
                    begin
                        att_v      = 1'b1;
                        phase_next = '0;
                        start_next = lvl_v;
                        cycle_next = 1'b1;
                    end
                    attack_next = att_v;
                    mvalid_next = 1'b1;
                    mdata_next  = lvl_v;
                    muser_next  = {att_v,
                                   cycle_next,
                                   rise_next};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= '0;
            attack_reg <= 1'b0;
            start_reg  <= '0;
            level_reg  <= '0;
            rise_reg   <= 1'b0;
            cycle_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            attack_reg <= attack_next;
            start_reg  <= start_next;
            level_reg  <= level_next;
            rise_reg   <= rise_next;
            cycle_reg  <= cycle_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        tge_reg   <= tge_next;
        zero_reg  <= zero_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    `LAE_ASSERT_IMP(a_done_in_div, clk, rst_n, div_rsp.done, state_reg == S_DIV,
        "divider finished while the sequencer was not waiting for it")
    `LAE_ASSERT_NXT(a_busy_after_beat, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input accepted again in the cycle after a beat")
    `LAE_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, state_reg == S_IDLE, !div_rsp.busy,
        "divider still running while the sequencer is idle")
    `LAE_ASSERT_NXT(a_result_posted, clk, rst_n, state_reg == S_DONE && out_free,
        m_tvalid && s_tready, "finished result was not posted to the output register")

endmodule
